FILE: rtl/led_matrix_pattern_generator_macros.svh
// ---------------------------------------------------------------------------
// LED matrix pattern generator assertion macros
// Property wrappers for the checks in the lmpg_ctrl module.
// ---------------------------------------------------------------------------
`ifndef LED_MATRIX_PATTERN_GENERATOR_MACROS_SVH
`define LED_MATRIX_PATTERN_GENERATOR_MACROS_SVH

// same-cycle implication
`define LMPG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LMPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lmpg_pkg.sv
// ---------------------------------------------------------------------------
// LED matrix pattern generator package
// Codes, field layout and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package lmpg_pkg;

   localparam int SIZE_W     = 4;
   localparam int CMD_W      = 3;
   localparam int REGION_W   = 3;
   localparam int RADIUS_W   = 8;
   localparam int LED_IDX_W  = 16;
   localparam int COLOR_W    = 8;
   localparam int PIX_W      = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;
   localparam int OUTER_W    = 2 * RADIUS_W + 2;

   localparam int REGION_LSB  = 0;
   localparam int RADIUS_LSB  = REGION_LSB + REGION_W;
   localparam int LED_IDX_LSB = RADIUS_LSB + RADIUS_W;
   localparam int RED_LSB     = LED_IDX_LSB + LED_IDX_W;
   localparam int GREEN_LSB   = RED_LSB + COLOR_W;
   localparam int BLUE_LSB    = GREEN_LSB + COLOR_W;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   localparam logic [CMD_W-1:0] CMD_OFF    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FILL   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SINGLE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HALVES = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CIRCLE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RING   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_NOP    = 3'd6;

   localparam logic [REGION_W-1:0] REGION_LEFT   = 3'd0;
   localparam logic [REGION_W-1:0] REGION_RIGHT  = 3'd1;
   localparam logic [REGION_W-1:0] REGION_TOP    = 3'd2;
   localparam logic [REGION_W-1:0] REGION_BOTTOM = 3'd3;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 4'd1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic frame_go;
      logic last_pixel;
      logic slot_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/led_matrix_pattern_generator.sv
// ---------------------------------------------------------------------------
// LED matrix pattern generator
// Turns one drawing command into a row-major frame of pixel colors.
// ---------------------------------------------------------------------------
// Flow: req_tready is low in ST_RUN, so frames do not overlap; each pixel word
//   is registered. A command without pixels leaves the controller in ST_IDLE.
// Throughput: one pixel per cycle from the scan counters while rsp_tready is high.
// Reset: size registers return to 8 x 8, lit flag clears, no pixel pending.
`default_nettype none

module led_matrix_pattern_generator #(
   parameter int MAX_WIDTH  = 8,
   parameter int MAX_HEIGHT = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // region, radius, led_index, red, green, blue
   input  wire logic [lmpg_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  wire logic [lmpg_pkg::CMD_W-1:0]      req_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lmpg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lmpg_pkg::SIZE_W-1:0]     csr_data,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // pixel_index, pixel_red, pixel_green, pixel_blue
   output logic [lmpg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   // lit
   output logic                                 rsp_tuser
);

   lmpg_pkg::ctrl_cmd_type  cmd;
   lmpg_pkg::dp_status_type status;

   lmpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lmpg_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

FILE: rtl/lmpg_ctrl.sv
// ---------------------------------------------------------------------------
// LED matrix pattern generator controller
// Accepts one command word, then steps the datapath over its frame, if it has one.
// ---------------------------------------------------------------------------
`default_nettype none

`include "led_matrix_pattern_generator_macros.svh"

module lmpg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire lmpg_pkg::dp_status_type status,
   output lmpg_pkg::ctrl_cmd_type      cmd
);

   lmpg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmpg_pkg::ST_IDLE: begin
            if (req_tvalid && status.frame_go) state_in = lmpg_pkg::ST_RUN;
         end
         lmpg_pkg::ST_RUN: begin
            if (status.slot_free && status.last_pixel) state_in = lmpg_pkg::ST_IDLE;
         end
         default: state_in = lmpg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      unique case (state_ff)
         lmpg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         lmpg_pkg::ST_RUN: begin
            cmd.step = status.slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   `LMPG_ASSERT_IMPL(a_step_needs_slot, clock, reset, cmd.step, status.slot_free, "step without free output slot")
   `LMPG_ASSERT_IMPL(a_no_load_and_step, clock, reset, cmd.load, !cmd.step, "load and step together")
   `LMPG_ASSERT_NEXT(a_last_ends_frame, clock, reset, cmd.step && status.last_pixel, state_ff == lmpg_pkg::ST_IDLE, "frame did not end after last pixel")
   `LMPG_ASSERT_NEXT(a_go_starts_frame, clock, reset, cmd.load && status.frame_go, state_ff == lmpg_pkg::ST_RUN, "frame did not start after accepted command")

endmodule

`default_nettype wire

FILE: rtl/lmpg_datapath.sv
// ---------------------------------------------------------------------------
// LED matrix pattern generator datapath
// Size registers, command capture, pixel scan counters and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lmpg_datapath #(
   parameter int MAX_WIDTH  = 8,
   parameter int MAX_HEIGHT = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [lmpg_pkg::CMD_W-1:0]          req_tuser,
   input  wire logic [lmpg_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lmpg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lmpg_pkg::SIZE_W-1:0]         csr_data,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [lmpg_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tuser,
   input  wire lmpg_pkg::ctrl_cmd_type              cmd,
   output lmpg_pkg::dp_status_type                  status
);

   localparam int SW = lmpg_pkg::SIZE_W;
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DW = SW + 2;
   localparam int SQ_W = 2 * DW;
   localparam int D2_W = SQ_W + 1;
   localparam int RW = lmpg_pkg::RADIUS_W;
   localparam int CW = lmpg_pkg::COLOR_W;
   localparam int OW = lmpg_pkg::OUTER_W;
   localparam int PW = lmpg_pkg::PIX_W;
   localparam int LW = lmpg_pkg::LED_IDX_W;

   function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] maxv);
      logic [SW-1:0] r;
      r = v;
      if (v == '0) r = {{(SW-1){1'b0}}, 1'b1};
      else if (v > maxv) r = maxv;
      return r;
   endfunction

   logic [SW-1:0] width_ff, width_in, height_ff, height_in;
   logic          lit_ff, lit_in;
   logic [lmpg_pkg::CMD_W-1:0]    cmd_ff;
   logic [lmpg_pkg::REGION_W-1:0] region_ff;
   logic [LW-1:0] index_ff;
   logic [CW-1:0] red_ff, green_ff, blue_ff;
   logic [OW-1:0] outer_ff, inner_ff;
   logic          rnz_ff;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [lmpg_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic          rsp_last_ff, rsp_lit_ff;

   logic [lmpg_pkg::CMD_W-1:0]    in_cmd;
   logic [lmpg_pkg::REGION_W-1:0] in_region;
   logic [RW-1:0] in_radius, in_rm1;
   logic [LW-1:0] in_index;
   logic [CW-1:0] in_red, in_green, in_blue;
   logic [2*RW-1:0] rsq, rm1sq;
   logic [SW-1:0] w, h, wm1, hm1;
   logic [2*SW-1:0] total;
   logic [SW-1:0] xe, ye;
   logic signed [DW-1:0] dx, dy;
   logic [SQ_W-1:0] dx_sq, dy_sq;
   logic [D2_W-1:0] d2;
   logic in_outer, in_inner, on, last;

   assign in_cmd    = req_tuser;
   assign in_region = req_tdata[lmpg_pkg::REGION_LSB +: lmpg_pkg::REGION_W];
   assign in_radius = req_tdata[lmpg_pkg::RADIUS_LSB +: RW];
   assign in_index  = req_tdata[lmpg_pkg::LED_IDX_LSB +: LW];
   assign in_red    = req_tdata[lmpg_pkg::RED_LSB +: CW];
   assign in_green  = req_tdata[lmpg_pkg::GREEN_LSB +: CW];
   assign in_blue   = req_tdata[lmpg_pkg::BLUE_LSB +: CW];
   assign in_rm1    = in_radius - {{(RW-1){1'b0}}, 1'b1};
   assign rsq       = {{RW{1'b0}}, in_radius} * {{RW{1'b0}}, in_radius};
   assign rm1sq     = {{RW{1'b0}}, in_rm1} * {{RW{1'b0}}, in_rm1};

   assign w     = clamp_size(width_ff, SW'(MAX_WIDTH));
   assign h     = clamp_size(height_ff, SW'(MAX_HEIGHT));
   assign wm1   = w - {{(SW-1){1'b0}}, 1'b1};
   assign hm1   = h - {{(SW-1){1'b0}}, 1'b1};
   assign total = {{SW{1'b0}}, w} * {{SW{1'b0}}, h};

   assign xe    = SW'(x_ff);
   assign ye    = SW'(y_ff);
   assign dx    = $signed({1'b0, xe, 1'b0}) - $signed({2'b00, wm1});
   assign dy    = $signed({1'b0, ye, 1'b0}) - $signed({2'b00, hm1});
   assign dx_sq = SQ_W'(dx * dx);
   assign dy_sq = SQ_W'(dy * dy);
   assign d2    = {1'b0, dx_sq} + {1'b0, dy_sq};
   assign in_outer = OW'(d2) <= outer_ff;
   assign in_inner = rnz_ff && (OW'(d2) <= inner_ff);
   assign last  = (xe == wm1) && (ye == hm1);

   always_comb begin
      on = 1'b0;
      case (cmd_ff)
         lmpg_pkg::CMD_FILL:   on = 1'b1;
         lmpg_pkg::CMD_SINGLE: on = ({{(LW-PW){1'b0}}, idx_ff} == index_ff);
         lmpg_pkg::CMD_HALVES: begin
            case (region_ff)
               lmpg_pkg::REGION_LEFT:   on = xe < (w >> 1);
               lmpg_pkg::REGION_RIGHT:  on = xe >= (w >> 1);
               lmpg_pkg::REGION_TOP:    on = ye < (h >> 1);
               lmpg_pkg::REGION_BOTTOM: on = ye >= (h >> 1);
               default:                 on = 1'b0;
            endcase
         end
         lmpg_pkg::CMD_CIRCLE: on = in_outer;
         lmpg_pkg::CMD_RING:   on = in_outer && !in_inner;
         default:              on = 1'b0;
      endcase
   end

   assign status.frame_go   = (in_cmd < lmpg_pkg::CMD_NOP) &&
                              !((in_cmd == lmpg_pkg::CMD_SINGLE) &&
                                (in_index >= {{(LW-2*SW){1'b0}}, total}));
   assign status.last_pixel = last;
   assign status.slot_free  = !rsp_valid_ff || rsp_tready;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lmpg_pkg::REG_WIDTH:  width_in  = csr_data;
            lmpg_pkg::REG_HEIGHT: height_in = csr_data;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_comb begin
      lit_in = lit_ff;
      if (cmd.load && (in_cmd < lmpg_pkg::CMD_NOP)) begin
         lit_in = (in_cmd != lmpg_pkg::CMD_OFF) && ((in_red | in_green | in_blue) != '0);
      end
   end

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         x_in   = '0;
         y_in   = '0;
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + {{(PW-1){1'b0}}, 1'b1};
         if (xe == wm1) begin
            x_in = '0;
            y_in = y_ff + {{(YW-1){1'b0}}, 1'b1};
         end else begin
            x_in = x_ff + {{(XW-1){1'b0}}, 1'b1};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.step) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= lmpg_pkg::SIZE_RESET;
         height_ff    <= lmpg_pkg::SIZE_RESET;
         lit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         lit_ff       <= lit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      idx_ff <= idx_in;
      if (cmd.load) begin
         cmd_ff    <= in_cmd;
         region_ff <= in_region;
         index_ff  <= in_index;
         red_ff    <= in_red;
         green_ff  <= in_green;
         blue_ff   <= in_blue;
         outer_ff  <= {rsq, 2'b00};
         inner_ff  <= {rm1sq, 2'b00};
         rnz_ff    <= in_radius != '0;
      end
      if (cmd.step) begin
         rsp_data_ff <= {{(lmpg_pkg::RSP_DATA_W - PW - 3 * CW){1'b0}},
                         on ? blue_ff : {CW{1'b0}},
                         on ? green_ff : {CW{1'b0}},
                         on ? red_ff : {CW{1'b0}},
                         idx_ff};
         rsp_last_ff <= last;
         rsp_lit_ff  <= lit_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_lit_ff;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LED matrix pattern generator testbench
// Sends drawing commands under several matrix sizes, predicts every pixel
// word of each frame in order and compares each field of the returned words.
// Both stream sides idle at random; the pixel side also holds off for a
// long stretch so that the command side has to stall.
// ---------------------------------------------------------------------------

module tb_top;

   localparam int MAX_W = 8;
   localparam int MAX_H = 8;
   localparam longint CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 100;
   localparam int SETTLE_CYCLES = 10;

   localparam int SW   = lmpg_pkg::SIZE_W;
   localparam int CMDW = lmpg_pkg::CMD_W;
   localparam int REGW = lmpg_pkg::REGION_W;
   localparam int RADW = lmpg_pkg::RADIUS_W;
   localparam int LEDW = lmpg_pkg::LED_IDX_W;
   localparam int COLW = lmpg_pkg::COLOR_W;
   localparam int PIXW = lmpg_pkg::PIX_W;
   localparam int CSRW = lmpg_pkg::CSR_IDX_W;

   typedef struct {
      logic [CMDW-1:0] cmd;
      logic [REGW-1:0] region;
      logic [RADW-1:0] radius;
      logic [LEDW-1:0] led_index;
      logic [COLW-1:0] red;
      logic [COLW-1:0] green;
      logic [COLW-1:0] blue;
   } draw_cmd_type;

   typedef struct {
      logic [PIXW-1:0] index;
      logic [COLW-1:0] red;
      logic [COLW-1:0] green;
      logic [COLW-1:0] blue;
      logic            frame_end;
      logic            lit;
   } pixel_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [lmpg_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [CMDW-1:0]                 req_tuser;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [CSRW-1:0]                 csr_index;
   logic [SW-1:0]                   csr_data;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [lmpg_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;

   pixel_type     pixel_q[$];
   logic [SW-1:0] cols_set;
   logic [SW-1:0] rows_set;
   logic          lit_state;
   int            error_count;
   int            word_count;
   int            stall_left;
   bit            quiet_run;
   longint        cycle_count;

   led_matrix_pattern_generator #(
      .MAX_WIDTH(MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic int clamp_size(logic [SW-1:0] v, int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   // queue the pixel words one command produces and update the lit flag
   function automatic void predict_frame(draw_cmd_type c);
      int w, h, total, outer, inner, dx, dy, d2, idx;
      bit on;
      pixel_type p;
      if (c.cmd >= lmpg_pkg::CMD_NOP) return;
      w = clamp_size(cols_set, MAX_W);
      h = clamp_size(rows_set, MAX_H);
      total = w * h;
      outer = 4 * int'(c.radius) * int'(c.radius);
      inner = (c.radius > 0) ? 4 * (int'(c.radius) - 1) * (int'(c.radius) - 1) : 0;
      lit_state = (c.cmd != lmpg_pkg::CMD_OFF) && ((c.red | c.green | c.blue) != 0);
      if (c.cmd == lmpg_pkg::CMD_SINGLE && int'(c.led_index) >= total) return;
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            idx = y * w + x;
            dx = 2 * x - (w - 1);
            dy = 2 * y - (h - 1);
            d2 = dx * dx + dy * dy;
            case (c.cmd)
               lmpg_pkg::CMD_FILL:   on = 1'b1;
               lmpg_pkg::CMD_SINGLE: on = (idx == int'(c.led_index));
               lmpg_pkg::CMD_HALVES: begin
                  case (c.region)
                     lmpg_pkg::REGION_LEFT:   on = x < w / 2;
                     lmpg_pkg::REGION_RIGHT:  on = x >= w / 2;
                     lmpg_pkg::REGION_TOP:    on = y < h / 2;
                     lmpg_pkg::REGION_BOTTOM: on = y >= h / 2;
                     default:                 on = 1'b0;
                  endcase
               end
               lmpg_pkg::CMD_CIRCLE: on = d2 <= outer;
               lmpg_pkg::CMD_RING:   on = (d2 <= outer) && !(c.radius > 0 && d2 <= inner);
               default:              on = 1'b0;
            endcase
            p.index = idx[PIXW-1:0];
            p.red = on ? c.red : '0;
            p.green = on ? c.green : '0;
            p.blue = on ? c.blue : '0;
            p.frame_end = (idx + 1 == total);
            p.lit = lit_state;
            pixel_q.push_back(p);
         end
      end
   endfunction

   function automatic draw_cmd_type make_cmd(logic [CMDW-1:0] cmd, logic [REGW-1:0] region,
                                             logic [RADW-1:0] radius,
                                             logic [LEDW-1:0] led_index,
                                             logic [COLW-1:0] red, logic [COLW-1:0] green,
                                             logic [COLW-1:0] blue);
      draw_cmd_type c;
      c.cmd = cmd;
      c.region = region;
      c.radius = radius;
      c.led_index = led_index;
      c.red = red;
      c.green = green;
      c.blue = blue;
      return c;
   endfunction

   function automatic logic [COLW-1:0] random_color();
      if ($urandom_range(99) < 10) return '0;
      return COLW'($urandom_range(255));
   endfunction

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int total;
      total = clamp_size(cols_set, MAX_W) * clamp_size(rows_set, MAX_H);
      c.cmd = CMDW'($urandom_range(7));
      c.region = REGW'($urandom_range(7));
      c.radius = ($urandom_range(99) < 70) ? RADW'($urandom_range(6))
                                             : RADW'($urandom_range(255));
      c.led_index = ($urandom_range(99) < 80) ? LEDW'($urandom_range(total - 1))
                                                : LEDW'($urandom_range(65535));
      c.red = random_color();
      c.green = random_color();
      c.blue = random_color();
      return c;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < 40)
         $display("tb_top: mismatch in %s at word %0d: got %0d, want %0d",
                  what, word_count, got, want);
      error_count++;
   endtask

   task automatic send_cmd(draw_cmd_type c);
      if (!quiet_run && $urandom_range(99) < 37) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= c.cmd;
      req_tdata <= {5'd0, c.blue, c.green, c.red, c.led_index, c.radius, c.region};
      do @(posedge clock); while (!req_tready);
      predict_frame(c);
   endtask

   // drop valid and wait until every pixel word is back and the scan is done
   task automatic drain_frames();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSRW-1:0] index, logic [SW-1:0] value);
      drain_frames();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == lmpg_pkg::REG_WIDTH) cols_set = value;
      else if (index == lmpg_pkg::REG_HEIGHT) rows_set = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(int cols, int rows);
      write_reg(lmpg_pkg::REG_WIDTH, SW'(cols));
      write_reg(lmpg_pkg::REG_HEIGHT, SW'(rows));
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= quiet_run || ($urandom_range(99) >= 37);
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            report_mismatch("unexpected word, index", int'(rsp_tdata[5:0]), -1);
         end else begin
            want = pixel_q.pop_front();
            if (rsp_tdata[5:0] != want.index)
               report_mismatch("pixel_index", int'(rsp_tdata[5:0]), int'(want.index));
            if (rsp_tdata[13:6] != want.red)
               report_mismatch("pixel_red", int'(rsp_tdata[13:6]), int'(want.red));
            if (rsp_tdata[21:14] != want.green)
               report_mismatch("pixel_green", int'(rsp_tdata[21:14]), int'(want.green));
            if (rsp_tdata[29:22] != want.blue)
               report_mismatch("pixel_blue", int'(rsp_tdata[29:22]), int'(want.blue));
            if (rsp_tlast != want.frame_end)
               report_mismatch("frame_end", int'(rsp_tlast), int'(want.frame_end));
            if (rsp_tuser != want.lit)
               report_mismatch("lit", int'(rsp_tuser), int'(want.lit));
         end
         word_count++;
      end
   end

   task automatic test_directed();
      send_cmd(make_cmd(lmpg_pkg::CMD_OFF, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd255, 8'd255, 8'd255));
      send_cmd(make_cmd(lmpg_pkg::CMD_FILL, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd255, 8'd255, 8'd255));
      send_cmd(make_cmd(lmpg_pkg::CMD_FILL, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd0, 8'd0, 8'd0));
      send_cmd(make_cmd(lmpg_pkg::CMD_FILL, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd0, 8'd0, 8'd1));
      send_cmd(make_cmd(lmpg_pkg::CMD_SINGLE, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd1, 8'd2, 8'd3));
      send_cmd(make_cmd(lmpg_pkg::CMD_SINGLE, lmpg_pkg::REGION_LEFT, 8'd0, 16'd63,
                        8'd255, 8'd0, 8'd128));
      send_cmd(make_cmd(lmpg_pkg::CMD_SINGLE, lmpg_pkg::REGION_LEFT, 8'd0, 16'd64,
                        8'd9, 8'd9, 8'd9));
      send_cmd(make_cmd(lmpg_pkg::CMD_SINGLE, lmpg_pkg::REGION_LEFT, 8'd0, 16'hFFFF,
                        8'd0, 8'd0, 8'd0));
      for (int r = 0; r < 8; r++)
         send_cmd(make_cmd(lmpg_pkg::CMD_HALVES, REGW'(r), 8'd0, 16'd0,
                           8'd10, 8'd20, 8'd30));
      send_cmd(make_cmd(lmpg_pkg::CMD_CIRCLE, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd50, 8'd60, 8'd70));
      send_cmd(make_cmd(lmpg_pkg::CMD_CIRCLE, lmpg_pkg::REGION_LEFT, 8'd3, 16'd0,
                        8'd50, 8'd60, 8'd70));
      send_cmd(make_cmd(lmpg_pkg::CMD_CIRCLE, lmpg_pkg::REGION_LEFT, 8'd255, 16'd0,
                        8'd50, 8'd60, 8'd70));
      send_cmd(make_cmd(lmpg_pkg::CMD_RING, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd1, 8'd1, 8'd1));
      send_cmd(make_cmd(lmpg_pkg::CMD_RING, lmpg_pkg::REGION_LEFT, 8'd1, 16'd0,
                        8'd1, 8'd1, 8'd1));
      send_cmd(make_cmd(lmpg_pkg::CMD_RING, lmpg_pkg::REGION_LEFT, 8'd4, 16'd0,
                        8'd1, 8'd1, 8'd1));
      send_cmd(make_cmd(lmpg_pkg::CMD_NOP, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd0, 8'd0, 8'd0));
      send_cmd(make_cmd(lmpg_pkg::CMD_NOP + 3'd1, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd0, 8'd0, 8'd0));
      send_cmd(make_cmd(lmpg_pkg::CMD_FILL, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd5, 8'd5, 8'd5));
   endtask

   task automatic test_sizes();
      int sizes[10][2] = '{'{1, 1}, '{8, 1}, '{1, 8}, '{0, 0}, '{15, 15},
                           '{9, 3}, '{5, 7}, '{2, 6}, '{3, 3}, '{8, 8}};
      int total;
      foreach (sizes[i]) begin
         set_size(sizes[i][0], sizes[i][1]);
         total = clamp_size(cols_set, MAX_W) * clamp_size(rows_set, MAX_H);
         send_cmd(make_cmd(lmpg_pkg::CMD_FILL, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                           random_color(), random_color(), random_color()));
         send_cmd(make_cmd(lmpg_pkg::CMD_CIRCLE, lmpg_pkg::REGION_LEFT,
                           RADW'($urandom_range(4)), 16'd0, 8'd7, 8'd8, 8'd9));
         send_cmd(make_cmd(lmpg_pkg::CMD_RING, lmpg_pkg::REGION_LEFT,
                           RADW'($urandom_range(4, 1)), 16'd0, 8'd11, 8'd12, 8'd13));
         send_cmd(make_cmd(lmpg_pkg::CMD_HALVES, REGW'($urandom_range(3)), 8'd0, 16'd0,
                           8'd40, 8'd41, 8'd42));
         send_cmd(make_cmd(lmpg_pkg::CMD_SINGLE, lmpg_pkg::REGION_LEFT, 8'd0,
                           LEDW'($urandom_range(total - 1)), 8'd90, 8'd91, 8'd92));
      end
      set_size(3, 5);
      for (int i = lmpg_pkg::REG_HEIGHT + 1; i < (1 << CSRW); i++)
         write_reg(CSRW'(i), SW'($urandom_range(15)));
      write_reg(4'd15, 4'd0);
      send_cmd(make_cmd(lmpg_pkg::CMD_FILL, lmpg_pkg::REGION_LEFT, 8'd0, 16'd0,
                        8'd33, 8'd34, 8'd35));
   endtask

   task automatic test_backpressure();
      set_size(8, 8);
      @(posedge clock);
      stall_left = 400;
      for (int i = 0; i < 10; i++) send_cmd(random_cmd());
      drain_frames();
      for (int i = 0; i < 6; i++) send_cmd(random_cmd());
   endtask

   task automatic test_random();
      int cols, rows;
      for (int i = 0; i < 300; i++) begin
         if (i % 30 == 0) begin
            cols = ($urandom_range(99) < 80) ? int'($urandom_range(MAX_W, 1))
                                              : int'($urandom_range(15));
            rows = ($urandom_range(99) < 80) ? int'($urandom_range(MAX_H, 1))
                                              : int'($urandom_range(15));
            set_size(cols, rows);
         end
         quiet_run = (i >= 120 && i < 180);
         send_cmd(random_cmd());
      end
      quiet_run = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_tready = 1'b0;
      cols_set = lmpg_pkg::SIZE_RESET;
      rows_set = lmpg_pkg::SIZE_RESET;
      lit_state = 1'b0;
      error_count = 0;
      word_count = 0;
      stall_left = 0;
      quiet_run = 1'b0;
      cycle_count = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_sizes();
      test_backpressure();
      test_random();

      drain_frames();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
